// File: design/rhr_pkg.sv
`timescale 1ns / 1ps

package rhr_pkg;

    // Fixed-point format of the matrix coefficients
    localparam int COEF_FRAC_BITS = 14;
    localparam int COEF_W         = COEF_FRAC_BITS + 2;
    localparam int SUM_W          = COEF_W + 11;

    // Table building works in Q30
    localparam int          WORK_BITS     = 30;
    localparam longint      WORK_ONE      = longint'(1) << WORK_BITS;
    localparam logic [63:0] PI_Q30        = 64'd3373259426;
    localparam logic [63:0] INV_SQRT3_Q30 = 64'd619925131;
    localparam int          TAYLOR_TERMS  = 7;
    localparam int          COEF_SHIFT    = WORK_BITS - COEF_FRAC_BITS;

    // Series divisors (2k)(2k+1) for sine and (2k-1)(2k) for cosine
    localparam int SIN_DIV [1:TAYLOR_TERMS] = '{6, 20, 42, 72, 110, 156, 210};
    localparam int COS_DIV [1:TAYLOR_TERMS] = '{2, 12, 30, 56, 90, 132, 182};

    // Angle handling
    localparam int DEG_W       = 9;
    localparam int FULL_TURN   = 360;
    localparam int QUARTER     = 90;
    localparam int TABLE_DEPTH = QUARTER;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int QUAD_W      = 2;
    localparam int QUADS       = 1 << QUAD_W;

    // Pixel channel format
    localparam int CH_W   = 8;
    localparam int CH_MAX = (1 << CH_W) - 1;

    typedef logic signed [COEF_W-1:0] coef_t;

    // One matrix: row 0 is [a b c], row 1 [c a b], row 2 [b c a]
    typedef struct packed {
        coef_t a;
        coef_t b;
        coef_t c;
    } coef_set_t;

    typedef coef_set_t [QUADS-1:0]       coef_row_t;
    typedef coef_row_t [TABLE_DEPTH-1:0] coef_table_t;

    // Q30 value rounded half up to the coefficient format
    function automatic coef_t to_coef(input longint v);
        logic [63:0] u;
        u = 64'(v + 4 * WORK_ONE);
        u = (u + (64'd1 << (COEF_SHIFT - 1))) >> COEF_SHIFT;
        return COEF_W'(longint'(u) - (longint'(4) << COEF_FRAC_BITS));
    endfunction

    // Coefficients for angle quad*90 + d, d in 0..89
    function automatic coef_set_t coef_for_angle(input int d, input int quad);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] mag;
        longint      acc;
        longint      sr;
        longint      cr;
        longint      sn;
        longint      cs;
        longint      t;
        longint      kk;
        coef_set_t   res;
        x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
        x2   = (x * x) >> WORK_BITS;
        // sine series
        term = x;
        acc  = longint'(x);
        for (int k = 1; k <= TAYLOR_TERMS; k++)
        begin
            term = ((term * x2) >> WORK_BITS) / 64'(SIN_DIV[k]);
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        sr   = acc;
        // cosine series
        term = 64'(WORK_ONE);
        acc  = WORK_ONE;
        for (int k = 1; k <= TAYLOR_TERMS; k++)
        begin
            term = ((term * x2) >> WORK_BITS) / 64'(COS_DIV[k]);
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        cr = acc;
        // quadrant fold
        case (quad)
            0:       begin sn = sr;  cs = cr;  end
            1:       begin sn = cr;  cs = -sr; end
            2:       begin sn = -sr; cs = -cr; end
            default: begin sn = -cr; cs = sr;  end
        endcase
        t   = (WORK_ONE - cs + 1) / 3;
        mag = (sn < 0) ? 64'(-sn) : 64'(sn);
        kk  = longint'((mag * INV_SQRT3_Q30 + (64'd1 << (WORK_BITS - 1))) >> WORK_BITS);
        if (sn < 0)
            kk = -kk;
        res.a = to_coef(cs + t);
        res.b = to_coef(t - kk);
        res.c = to_coef(t + kk);
        return res;
    endfunction

    function automatic coef_table_t build_coef_table();
        coef_table_t tbl;
        for (int d = 0; d < TABLE_DEPTH; d++)
        begin
            for (int q = 0; q < QUADS; q++)
            begin
                tbl[d][q] = coef_for_angle(d, q);
            end
        end
        return tbl;
    endfunction

    // Per-degree coefficient table: one row per degree within a quadrant
    localparam coef_table_t COEF_TABLE = build_coef_table();

    // Identity matrix after reset
    localparam coef_set_t COEF_IDENTITY = '{
        a: coef_t'(longint'(1) << COEF_FRAC_BITS),
        b: '0,
        c: '0
    };

endpackage

// File: design/rgb_hue_rotation_top.sv
`timescale 1ns / 1ps

// RGBA hue rotation. Each pixel word is multiplied by a circulant 3x3 color
// matrix chosen by the angle register (whole degrees; 360..511 wrap once),
// rounded half up and clamped to 0..255; alpha is copied. Pixels stream at one
// word per clock while the output is not stalled and no cfg write is under way:
// an input register, then the matrix multiply and rounding into the result
// register. A write on the cfg channel goes through three steps (word taken, angle
// folded into a quadrant, coefficient table read); during the fold and the table read, cfg_ready and s_tready are low.
// After reset the matrix is the identity.
module rgb_hue_rotation_top
    import rhr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // angle register write
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [DEG_W-1:0] cfg_data,      // hue_degrees
    // pixel input
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,       // red_in, green_in, blue_in, alpha_in
    // pixel output
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata        // red_out, green_out, blue_out, alpha_out
);

    coef_set_t coef;
    logic      busy;

    rhr_coef_loader u_loader (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .coef      (coef)
    );

    rhr_pixel_path u_path (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (busy),
        .coef      (coef),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red_in    (s_tdata[7:0]),
        .green_in  (s_tdata[15:8]),
        .blue_in   (s_tdata[23:16]),
        .alpha_in  (s_tdata[31:24]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .red_out   (m_tdata[7:0]),
        .green_out (m_tdata[15:8]),
        .blue_out  (m_tdata[23:16]),
        .alpha_out (m_tdata[31:24])
    );

endmodule

// File: design/rhr_coef_loader.sv
`timescale 1ns / 1ps

module rhr_coef_loader
    import rhr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [DEG_W-1:0] cfg_data,
    output logic             busy,
    output coef_set_t        coef
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_REDUCE = 3'b010,
        ST_LOOKUP = 3'b100
    } load_state_t;

    load_state_t       state_reg, state_next;
    logic [DEG_W-1:0]  deg_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [QUAD_W-1:0] quad_reg;
    coef_set_t         coef_reg;

    logic [DEG_W-1:0]  deg_turn;
    logic [DEG_W-1:0]  deg_in_quad;
    logic [QUAD_W-1:0] quad_next;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign coef      = coef_reg;

    // Fold the angle into one turn, then into a quadrant and offset
    always_comb
    begin
        deg_turn = (deg_reg >= DEG_W'(FULL_TURN)) ? deg_reg - DEG_W'(FULL_TURN) : deg_reg;
        if (deg_turn >= DEG_W'(3 * QUARTER))
        begin
            quad_next   = QUAD_W'(3);
            deg_in_quad = deg_turn - DEG_W'(3 * QUARTER);
        end
        else if (deg_turn >= DEG_W'(2 * QUARTER))
        begin
            quad_next   = QUAD_W'(2);
            deg_in_quad = deg_turn - DEG_W'(2 * QUARTER);
        end
        else if (deg_turn >= DEG_W'(QUARTER))
        begin
            quad_next   = QUAD_W'(1);
            deg_in_quad = deg_turn - DEG_W'(QUARTER);
        end
        else
        begin
            quad_next   = '0;
            deg_in_quad = deg_turn;
        end
    end

    // Sequencer: take the word, reduce, look up
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (cfg_valid) state_next = ST_REDUCE;
            ST_REDUCE: state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            coef_reg  <= COEF_IDENTITY;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_LOOKUP)
                coef_reg <= COEF_TABLE[idx_reg][quad_reg];
        end
    end

    // Angle datapath
    always_ff @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
            deg_reg <= cfg_data;
        if (state_reg == ST_REDUCE)
        begin
            idx_reg  <= deg_in_quad[IDX_W-1:0];
            quad_reg <= quad_next;
        end
    end

endmodule

// File: design/rhr_pixel_path.sv
`timescale 1ns / 1ps

module rhr_pixel_path
    import rhr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            hold,
    input  coef_set_t       coef,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [CH_W-1:0] red_in,
    input  logic [CH_W-1:0] green_in,
    input  logic [CH_W-1:0] blue_in,
    input  logic [CH_W-1:0] alpha_in,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [CH_W-1:0] red_out,
    output logic [CH_W-1:0] green_out,
    output logic [CH_W-1:0] blue_out,
    output logic [CH_W-1:0] alpha_out
);

    logic            in_vld_reg;
    logic [CH_W-1:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic            out_vld_reg;
    logic [CH_W-1:0] red_o_reg, green_o_reg, blue_o_reg, alpha_o_reg;
    logic            advance;
    logic            take;
    logic [CH_W-1:0] red_next, green_next, blue_next;

    // Exact dot product of one matrix row
    function automatic logic signed [SUM_W-1:0] dot3(
        input logic [CH_W-1:0] x0,
        input logic [CH_W-1:0] x1,
        input logic [CH_W-1:0] x2,
        input coef_t           k0,
        input coef_t           k1,
        input coef_t           k2
    );
        logic signed [SUM_W-1:0] p0;
        logic signed [SUM_W-1:0] p1;
        logic signed [SUM_W-1:0] p2;
        p0 = $signed(SUM_W'(x0)) * SUM_W'(k0);
        p1 = $signed(SUM_W'(x1)) * SUM_W'(k1);
        p2 = $signed(SUM_W'(x2)) * SUM_W'(k2);
        return p0 + p1 + p2;
    endfunction

    // Round half up and clamp to the channel range
    function automatic logic [CH_W-1:0] round_clamp(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] v;
        v = (SUM_W'(s) + (SUM_W'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
        if (s < 0)
            return '0;
        else if (v > SUM_W'(CH_MAX))
            return CH_W'(CH_MAX);
        else
            return v[CH_W-1:0];
    endfunction

    assign advance  = !out_vld_reg || out_ready;
    assign in_ready = (!in_vld_reg || advance) && !hold;
    assign take     = in_valid && in_ready;

    assign red_next   = round_clamp(dot3(red_reg, green_reg, blue_reg, coef.a, coef.b, coef.c));
    assign green_next = round_clamp(dot3(red_reg, green_reg, blue_reg, coef.c, coef.a, coef.b));
    assign blue_next  = round_clamp(dot3(red_reg, green_reg, blue_reg, coef.b, coef.c, coef.a));

    // Valid flags of the input and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (take)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;
            if (advance)
                out_vld_reg <= in_vld_reg;
        end
    end

    // Pixel data
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            red_reg   <= red_in;
            green_reg <= green_in;
            blue_reg  <= blue_in;
            alpha_reg <= alpha_in;
        end
        if (advance && in_vld_reg)
        begin
            red_o_reg   <= red_next;
            green_o_reg <= green_next;
            blue_o_reg  <= blue_next;
            alpha_o_reg <= alpha_reg;
        end
    end

    assign out_valid = out_vld_reg;
    assign red_out   = red_o_reg;
    assign green_out = green_o_reg;
    assign blue_out  = blue_o_reg;
    assign alpha_out = alpha_o_reg;

endmodule

// File: design/rhr_checker.sv
`timescale 1ns / 1ps

module rhr_checker
    import rhr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [31:0]      s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [31:0]      m_tdata
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // A coefficient refill blocks pixels
    a_refill_blocks_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_tready)
        else $error("pixel taken during coefficient refill");

    // No second angle write during a refill
    a_refill_blocks_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !cfg_ready)
        else $error("angle write taken during coefficient refill");

    // With the output open, a taken pixel passes the input and result registers and appears with its alpha
    a_alpha_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready |=>
            m_tvalid && (m_tdata[31:24] == $past(s_tdata[31:24], 2)))
        else $error("alpha lost or late");

endmodule

bind rgb_hue_rotation_top rhr_checker u_rhr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
